// ===== hdl/obr_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the pcm lookup table of the resampler
package obr_pkg;

	localparam int unsigned MAX_RECORD_BYTES = 4096;

	localparam logic [15:0] MAX_BITS   = 16'(MAX_RECORD_BYTES * 8);
	localparam logic [18:0] STEP_MIN   = 19'd16384;
	localparam logic [18:0] STEP_MAX   = 19'd262144;
	localparam logic [18:0] STEP_RESET = 19'd98514;
	localparam int unsigned MAX_OUT    = 40;
	localparam int unsigned CNT_W      = $clog2(MAX_OUT + 1);

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 19;
	localparam logic [CFG_IDX_W-1:0] REG_STEP     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE = 1'd1;

	// 28 + floor(ones*200/n) capped at 228, row is n (n of zero counts as one), column is ones
	localparam logic [7:0] PCM_LUT [0:8][0:8] = '{
		'{8'd28, 8'd228, 8'd228, 8'd228, 8'd228, 8'd228, 8'd228, 8'd228, 8'd228},
		'{8'd28, 8'd228, 8'd228, 8'd228, 8'd228, 8'd228, 8'd228, 8'd228, 8'd228},
		'{8'd28, 8'd128, 8'd228, 8'd228, 8'd228, 8'd228, 8'd228, 8'd228, 8'd228},
		'{8'd28, 8'd94,  8'd161, 8'd228, 8'd228, 8'd228, 8'd228, 8'd228, 8'd228},
		'{8'd28, 8'd78,  8'd128, 8'd178, 8'd228, 8'd228, 8'd228, 8'd228, 8'd228},
		'{8'd28, 8'd68,  8'd108, 8'd148, 8'd188, 8'd228, 8'd228, 8'd228, 8'd228},
		'{8'd28, 8'd61,  8'd94,  8'd128, 8'd161, 8'd194, 8'd228, 8'd228, 8'd228},
		'{8'd28, 8'd56,  8'd85,  8'd113, 8'd142, 8'd170, 8'd199, 8'd228, 8'd228},
		'{8'd28, 8'd53,  8'd78,  8'd103, 8'd128, 8'd153, 8'd178, 8'd203, 8'd228}
	};

	// controller to datapath
	typedef struct packed {
		logic load;       // input item accepted
		logic latch;      // capture window end of the next sample
		logic sum;        // count ones in the window, advance position
		logic look;       // look up pcm value into the pending register
		logic push;       // move pending sample into the output register
		logic push_last;  // pushed sample closes the run of this item
		logic finish;     // item done, clear record state on last byte
	} obr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cont;       // another sample is due
		logic pend_v;     // pending sample held
		logic out_free;   // output register can take a sample
	} obr_sts_t;

endpackage

// ===== hdl/obr_ifs.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces of the resampler
interface obr_rec_if;
	logic       valid;
	logic       ready;
	logic [7:0] record_byte;
	logic       last_byte;
	modport source (output valid, input ready, output record_byte, output last_byte);
	modport sink (input valid, output ready, input record_byte, input last_byte);
endinterface

interface obr_pcm_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample;
	logic       last_of_run;
	modport source (output valid, input ready, output sample, output last_of_run);
	modport sink (input valid, output ready, input sample, input last_of_run);
endinterface

interface obr_cfg_if
	import obr_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, input ready, output index, output data);
	modport sink (input valid, output ready, input index, input data);
endinterface

// ===== hdl/obr_datapath.sv =====
`timescale 1ns / 1ps
// resampler datapath: config registers, record state, window sum, output register
module obr_datapath
	import obr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  obr_cmd_t   cmd,
	output obr_sts_t   sts,
	input  logic [7:0] record_byte,
	input  logic       last_byte,
	obr_cfg_if.sink    cfg,
	obr_pcm_if.source  pcm
);

	logic [18:0]      step_q;
	logic             raw_q;
	logic [31:0]      pos_q;
	logic [15:0]      bits_q;
	logic [15:0]      recent_q;
	logic             last_q;
	logic             rawi_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      end_q;
	logic [16:0]      i1_q;
	logic [3:0]       ones_s1;
	logic [3:0]       n_s1;
	logic [7:0]       pend_q;
	logic             pend_v_q;
	logic             out_v_q;
	logic [7:0]       out_sample_q;
	logic             out_last_q;

	logic [18:0] eff_step;
	logic [32:0] end_w;
	logic [32:0] lim_w;
	logic [16:0] i1_raw;
	logic [16:0] bits_x;
	logic [16:0] i1_w;
	logic [15:0] bits_nx;
	logic        cont_w;
	logic [17:0] d_w;
	logic [3:0]  n_w;
	logic [3:0]  base_w;
	logic [3:0]  ones_w;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			raw_q  <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_STEP:     step_q <= cfg.data;
				REG_RAW_MODE: raw_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// clamp step to 0.25 .. 4.0 bits
	always_comb begin
		eff_step = step_q;
		if (step_q < STEP_MIN) eff_step = STEP_MIN;
		if (step_q > STEP_MAX) eff_step = STEP_MAX;
	end

	assign end_w   = {1'b0, pos_q} + {14'd0, eff_step};
	assign lim_w   = {1'b0, bits_q, 16'd0};
	assign i1_raw  = end_w[32:16];
	assign bits_x  = {1'b0, bits_q};
	assign bits_nx = bits_q + 16'd8;

	always_comb begin
		if (rawi_q || cnt_q >= CNT_W'(MAX_OUT)) cont_w = 1'b0;
		else if (last_q)                         cont_w = (end_w <= lim_w);
		else                                     cont_w = (i1_raw < bits_x);
	end

	// window end bit, clamped to the final bit on the last byte
	assign i1_w = (last_q && i1_raw >= bits_x) ? bits_x - 17'd1 : i1_raw;

	// window length and ones count, at most eight bits
	assign d_w    = {1'b0, i1_q} - {2'b0, pos_q[31:16]};
	assign base_w = bits_q[3:0] - 4'd1 - pos_q[19:16];

	always_comb begin
		if (d_w[17])            n_w = 4'd0;
		else if (d_w >= 18'd7)  n_w = 4'd8;
		else                    n_w = d_w[3:0] + 4'd1;
	end

	always_comb begin
		ones_w = 4'd0;
		for (int j = 0; j < 8; j++) begin
			if (4'(j) < n_w) ones_w = ones_w + {3'd0, recent_q[base_w - 4'(j)]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			bits_q   <= '0;
			recent_q <= '0;
			last_q   <= 1'b0;
			rawi_q   <= 1'b0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				rawi_q <= raw_q;
				cnt_q  <= '0;
				if (raw_q) begin
					pend_v_q <= 1'b1;
				end else begin
					recent_q <= {recent_q[7:0], record_byte};
					bits_q   <= bits_nx;
					last_q   <= last_byte || (bits_nx >= MAX_BITS);
				end
			end
			if (cmd.sum) begin
				pos_q <= end_q;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.look) pend_v_q <= 1'b1;
			else if (cmd.push) pend_v_q <= 1'b0;
			if (cmd.finish && !rawi_q && last_q) begin
				pos_q    <= '0;
				bits_q   <= '0;
				recent_q <= '0;
			end
			if (cmd.push) out_v_q <= 1'b1;
			else if (pcm.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && raw_q) pend_q <= record_byte;
		if (cmd.latch) begin
			end_q <= end_w[31:0];
			i1_q  <= i1_w;
		end
		if (cmd.sum) begin
			ones_s1 <= ones_w;
			n_s1    <= n_w;
		end
		if (cmd.look) pend_q <= PCM_LUT[n_s1][ones_s1];
		if (cmd.push) begin
			out_sample_q <= pend_q;
			out_last_q   <= cmd.push_last;
		end
	end

	assign pcm.valid       = out_v_q;
	assign pcm.sample      = out_sample_q;
	assign pcm.last_of_run = out_last_q;

	assign sts.cont     = cont_w;
	assign sts.pend_v   = pend_v_q;
	assign sts.out_free = !out_v_q || pcm.ready;

endmodule

// ===== hdl/obr_ctrl.sv =====
`timescale 1ns / 1ps
// resampler controller: sequences check, sum and lookup for each sample of an item
module obr_ctrl
	import obr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  obr_sts_t sts,
	output obr_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CHECK = 4'b0010,
		S_SUM   = 4'b0100,
		S_LOOK  = 4'b1000
	} obr_state_t;

	obr_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nx;
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_CHECK;
				end
			end
			S_CHECK: begin
				// a held sample waits for the output register
				if (!sts.pend_v || sts.out_free) begin
					cmd.push      = sts.pend_v;
					cmd.push_last = !sts.cont;
					if (sts.cont) begin
						cmd.latch = 1'b1;
						state_nx  = S_SUM;
					end else begin
						cmd.finish = 1'b1;
						state_nx   = S_IDLE;
					end
				end
			end
			S_SUM: begin
				cmd.sum  = 1'b1;
				state_nx = S_LOOK;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_nx = S_CHECK;
			end
			default: state_nx = S_IDLE;
		endcase
	end

endmodule

// ===== hdl/one_bit_box_average_resampler.sv =====
`timescale 1ns / 1ps
// top level of the 1-bit record to 8-bit pcm box average resampler
//
// channel  dir  handshake            payload
// rec      in   rec.valid/ready      record_byte[7:0], last_byte
// pcm      out  pcm.valid/ready      sample[7:0], last_of_run
// cfg      in   cfg.valid/ready      index (0 step, 1 raw_mode), data[18:0]
//
// one item at a time: obr_ctrl loads it, then runs check, window sum and pcm
// lookup for each sample it produces; a final check closes the item
// a raw item is loaded and its byte is pushed as the sample in the check state
// the output register lets the next sample be worked on while one waits on pcm
// a stalled pcm channel holds the sequencer in its check state, nothing is lost
// arst_n clears position, bit count, recent bits and loads step 98514, raw off
module one_bit_box_average_resampler
	import obr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	obr_rec_if.sink    rec,
	obr_pcm_if.source  pcm,
	obr_cfg_if.sink    cfg
);

	obr_cmd_t cmd;
	obr_sts_t sts;
	logic     in_ready;

	// input side handshake comes from the controller
	assign rec.ready = in_ready;

	obr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rec.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// record state, window arithmetic and output register
	obr_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.record_byte (rec.record_byte),
		.last_byte   (rec.last_byte),
		.cfg         (cfg),
		.pcm         (pcm)
	);

endmodule
